>>> rtl/kdar_pkg.sv
package kdar_pkg;

  localparam int unsigned NumKeys = 4;
  localparam int unsigned TickW   = 16;
  localparam int unsigned KeyW    = 2;
  localparam int unsigned MaskW   = NumKeys;

  typedef logic [TickW-1:0] tick_t;
  typedef logic [KeyW-1:0]  key_t;
  typedef logic [MaskW-1:0] mask_t;

  typedef enum logic [1:0] {
    KindTick = 2'd0,
    KindRead = 2'd1,
    KindPeek = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EvPress   = 2'd0,
    EvRepeat  = 2'd1,
    EvRelease = 2'd2
  } ev_e;

  typedef enum logic [1:0] {
    RegDebounce     = 2'd0,
    RegRepeatStart  = 2'd1,
    RegRepeatPeriod = 2'd2,
    RegShortMask    = 2'd3
  } reg_e;

  localparam tick_t DebounceRst     = 16'd2;
  localparam tick_t RepeatStartRst  = 16'd50;
  localparam tick_t RepeatPeriodRst = 16'd10;
  localparam mask_t ShortMaskRst    = 4'b1000;

  // press phase visits keys in this order; the last event posted wins
  localparam key_t PressOrder [NumKeys] = '{2'd0, 2'd2, 2'd1, 2'd3};

  typedef struct packed {
    logic valid;
    key_t key;
    ev_e  ev;
  } mbox_t;

  function automatic tick_t sat_add(tick_t a, tick_t b);
    logic [TickW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TickW] ? {TickW{1'b1}} : s[TickW-1:0];
  endfunction

endpackage

>>> rtl/key_debounce_autorepeat.sv
// Four-key debounce with auto-repeat and a one-entry event mailbox.
// Input channel (in_valid_i/in_ready_o) carries requests: kind_i selects a
// tick sample of the active-low key_levels_i, a mailbox read with clear, or
// a mailbox peek. Ticks and unused kinds produce no result; read and peek
// each produce one result (has_event_o, key_id_o, event_type_o) on the
// output channel (out_valid_o/out_ready_i).
// A result is registered in the output register, or in the skid register if stalled.
// Throughput: one request per cycle while in_ready_o is high; all per-key
// counter, threshold and mailbox updates finish in the accepting cycle.
// Stall: a result waits in the output register; one more result fits in a
// skid register, so a request is still taken while the output is stalled.
// in_ready_o drops only while the skid register is full.
// Reset: counters clear, thresholds load the debounce delay, the mailbox is
// empty, and the registers take their defaults (debounce 2, repeat start 50,
// repeat period 10, short-release mask 8). Registers sit on the APB port at
// byte addresses 0, 4, 8, 12; write them only while the block is idle.
module key_debounce_autorepeat
  import kdar_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  key_levels_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_event_o,
  output logic [1:0]  key_id_o,
  output logic [1:0]  event_type_o
);

  tick_t db_q, rs_q, rp_q;
  mask_t mask_q;

  tick_t cnt_q [NumKeys];
  tick_t thr_q [NumKeys];
  tick_t cnt_d [NumKeys];
  tick_t thr_mid [NumKeys];
  tick_t thr_d [NumKeys];
  logic [NumKeys-1:0] rel_ev, pr_fire;
  ev_e   pr_ev [NumKeys];

  mbox_t mb_q, mb_d, mb_tick;
  mbox_t out_q, skid_q;
  logic  out_valid_q, skid_valid_q;

  logic [TickW:0] db_rs;
  logic in_acc, is_tick, is_read, produce, cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    unique case (reg_e'(paddr[3:2]))
      RegDebounce:     prdata = {16'd0, db_q};
      RegRepeatStart:  prdata = {16'd0, rs_q};
      RegRepeatPeriod: prdata = {16'd0, rp_q};
      RegShortMask:    prdata = {28'd0, mask_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q   <= DebounceRst;
      rs_q   <= RepeatStartRst;
      rp_q   <= RepeatPeriodRst;
      mask_q <= ShortMaskRst;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        RegDebounce:     db_q   <= pwdata[TickW-1:0];
        RegRepeatStart:  rs_q   <= pwdata[TickW-1:0];
        RegRepeatPeriod: rp_q   <= pwdata[TickW-1:0];
        RegShortMask:    mask_q <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // request decode
  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i & in_ready_o;
  assign is_tick    = (kind_i == KindTick);
  assign is_read    = (kind_i == KindRead);
  assign produce    = in_acc & ((kind_i == KindRead) | (kind_i == KindPeek));

  assign db_rs = {1'b0, db_q} + {1'b0, rs_q};

  // per-key release and press phases
  always_comb begin
    for (int k = 0; k < NumKeys; k++) begin
      if (!key_levels_i[k]) begin
        cnt_d[k]   = (cnt_q[k] == {TickW{1'b1}}) ? cnt_q[k] : cnt_q[k] + tick_t'(1);
        thr_mid[k] = thr_q[k];
        rel_ev[k]  = 1'b0;
      end else begin
        cnt_d[k]   = '0;
        thr_mid[k] = db_q;
        rel_ev[k]  = (thr_q[k] > db_q) && (!mask_q[k] || ({1'b0, thr_q[k]} <= db_rs));
      end
      pr_fire[k] = 1'b0;
      pr_ev[k]   = EvPress;
      thr_d[k]   = thr_mid[k];
      if (cnt_d[k] > thr_mid[k]) begin
        if (thr_mid[k] == db_q) begin
          pr_fire[k] = 1'b1;
          thr_d[k]   = sat_add(thr_mid[k], rs_q);
        end else if ({1'b0, thr_mid[k]} >= db_rs) begin
          pr_fire[k] = 1'b1;
          pr_ev[k]   = EvRepeat;
          thr_d[k]   = sat_add(thr_mid[k], rp_q);
        end
      end
    end
  end

  // last posted event wins
  always_comb begin
    mb_tick = mb_q;
    for (int k = 0; k < NumKeys; k++) begin
      if (rel_ev[k]) begin
        mb_tick = '{valid: 1'b1, key: key_t'(k), ev: EvRelease};
      end
    end
    for (int i = 0; i < NumKeys; i++) begin
      if (pr_fire[PressOrder[i]]) begin
        mb_tick = '{valid: 1'b1, key: PressOrder[i], ev: pr_ev[PressOrder[i]]};
      end
    end
  end

  always_comb begin
    mb_d = mb_q;
    if (in_acc && is_tick) begin
      mb_d = mb_tick;
    end else if (in_acc && is_read) begin
      mb_d = '{valid: 1'b0, key: '0, ev: EvPress};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '{default: '0};
      thr_q <= '{default: DebounceRst};
      mb_q  <= '{valid: 1'b0, key: '0, ev: EvPress};
    end else begin
      mb_q <= mb_d;
      if (in_acc && is_tick) begin
        cnt_q <= cnt_d;
        thr_q <= thr_d;
      end
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : mb_q;
    end else if (produce) begin
      skid_q <= mb_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign has_event_o  = out_q.valid;
  assign key_id_o     = out_q.key;
  assign event_type_o = out_q.ev;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_release_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_tick && key_levels_i[0]) |=> (cnt_q[0] == '0))
    else $error("released key kept a nonzero count");

  a_read_clears_mailbox: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read) |=> !mb_q.valid)
    else $error("mailbox not cleared by read request");

  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (produce && !skid_valid_q && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("result missing after read or peek request");

endmodule

>>> test/key_debounce_autorepeat_tb.sv
`timescale 1ns / 100ps

module key_debounce_autorepeat_tb
  import kdar_pkg::*;
;

  localparam logic [1:0] KindUnused = 2'd3;

  class key_event_tracker;
    tick_t debounce;
    tick_t rep_start;
    tick_t rep_period;
    mask_t short_mask;
    tick_t held_cnt [NumKeys];
    tick_t thresh [NumKeys];
    mbox_t mbox;
    mbox_t pending_events [$];
    int errors;

    function new();
      debounce   = DebounceRst;
      rep_start  = RepeatStartRst;
      rep_period = RepeatPeriodRst;
      short_mask = ShortMaskRst;
      for (int k = 0; k < NumKeys; k++) begin
        held_cnt[k] = '0;
        thresh[k]   = DebounceRst;
      end
      mbox   = '0;
      errors = 0;
    endfunction

    function tick_t add_clamped(tick_t a, tick_t b);
      logic [TickW:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total > {1'b0, {TickW{1'b1}}}) begin
        return {TickW{1'b1}};
      end
      return total[TickW-1:0];
    endfunction

    function void set_reg(reg_e r, logic [31:0] v);
      case (r)
        RegDebounce:     debounce   = v[TickW-1:0];
        RegRepeatStart:  rep_start  = v[TickW-1:0];
        RegRepeatPeriod: rep_period = v[TickW-1:0];
        RegShortMask:    short_mask = v[MaskW-1:0];
        default: ;
      endcase
    endfunction

    function void post(key_t k, ev_e e);
      mbox.valid = 1'b1;
      mbox.key   = k;
      mbox.ev    = e;
    endfunction

    function void take_request(logic [1:0] kind, logic [3:0] lv);
      logic [TickW:0] start_sum;
      key_t key;
      start_sum = {1'b0, debounce} + {1'b0, rep_start};
      case (kind)
        KindTick: begin
          for (int k = 0; k < NumKeys; k++) begin
            if (!lv[k]) begin
              held_cnt[k] = add_clamped(held_cnt[k], 16'd1);
            end else begin
              held_cnt[k] = '0;
              if (thresh[k] > debounce &&
                  (!short_mask[k] || {1'b0, thresh[k]} <= start_sum)) begin
                post(key_t'(k), EvRelease);
              end
              thresh[k] = debounce;
            end
          end
          for (int i = 0; i < NumKeys; i++) begin
            key = PressOrder[i];
            if (held_cnt[key] > thresh[key]) begin
              if (thresh[key] == debounce) begin
                thresh[key] = add_clamped(thresh[key], rep_start);
                post(key, EvPress);
              end else if ({1'b0, thresh[key]} >= start_sum) begin
                thresh[key] = add_clamped(thresh[key], rep_period);
                post(key, EvRepeat);
              end
            end
          end
        end
        KindRead, KindPeek: begin
          pending_events.push_back(mbox);
          if (kind == KindRead) begin
            mbox = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_event(logic has, logic [1:0] key, logic [1:0] ev);
      mbox_t want;
      if (pending_events.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %0d %0d %0d",
                 $time, has, key, ev);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (has !== want.valid) begin
        $display("%0t ns: has_event expected %0d actual %0d", $time, want.valid, has);
        errors++;
      end
      if (key !== want.key) begin
        $display("%0t ns: key_id expected %0d actual %0d", $time, want.key, key);
        errors++;
      end
      if (ev !== want.ev) begin
        $display("%0t ns: event_type expected %0d actual %0d", $time, want.ev, ev);
        errors++;
      end
    endfunction

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i       = KindTick;
  logic [3:0]  key_levels_i = 4'hF;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        has_event_o;
  logic [1:0]  key_id_o;
  logic [1:0]  event_type_o;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  key_event_tracker tracker;

  key_debounce_autorepeat u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .has_event_o  (has_event_o),
    .key_id_o     (key_id_o),
    .event_type_o (event_type_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_event(has_event_o, key_id_o, event_type_o);
    end
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        src_idle_pct   = 37;
        sink_stall_pct = 58;
      end
      1: begin
        src_idle_pct   = 58;
        sink_stall_pct = 37;
      end
      default: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_request(input logic [1:0] kind, input logic [3:0] lv);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    key_levels_i <= lv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_request(kind, lv);
  endtask

  // drop valid and let every outstanding result come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(r, v);
  endtask

  task automatic apply_settings(input tick_t deb, input tick_t start, input tick_t period,
                                input mask_t mask);
    write_reg(RegDebounce, 32'(deb));
    write_reg(RegRepeatStart, 32'(start));
    write_reg(RegRepeatPeriod, 32'(period));
    write_reg(RegShortMask, 32'(mask));
  endtask

  task automatic run_random(input int n_items);
    logic [3:0] hold_lv;
    logic [3:0] lv;
    int run_len;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      hold_lv = 4'($urandom_range(15));
      run_len = ($urandom_range(7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (int t = 0; t < run_len && sent < n_items; t++) begin
        lv = hold_lv;
        if ($urandom_range(9) == 0) begin
          lv[$urandom_range(3)] ^= 1'b1;
        end
        send_request(KindTick, lv);
        sent++;
        case ($urandom_range(19))
          0, 1, 2, 3: begin
            send_request(KindRead, 4'($urandom_range(15)));
            sent++;
          end
          4, 5: begin
            send_request(KindPeek, 4'($urandom_range(15)));
            sent++;
          end
          6: send_request(KindUnused, 4'($urandom_range(15)));
          default: ;
        endcase
      end
    end
  endtask

  initial begin
    #2000000;
    $display("key_debounce_autorepeat_tb NOT OK");
    $finish;
  end

  initial begin
    tracker = new();
    set_idling(0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(KindPeek, 4'hF);
    send_request(KindRead, 4'h0);
    send_request(KindUnused, 4'h0);
    send_request(KindTick, 4'hF);
    repeat (3) send_request(KindTick, 4'h0);
    send_request(KindPeek, 4'h0);
    send_request(KindRead, 4'h0);
    send_request(KindRead, 4'h0);
    send_request(KindTick, 4'hF);
    send_request(KindRead, 4'hF);
    settle();

    apply_settings(16'd1, 16'd2, 16'd0, 4'hF);
    repeat (5) send_request(KindTick, 4'b1101);
    send_request(KindRead, 4'b0010);
    send_request(KindTick, 4'hF);
    send_request(KindRead, 4'h0);
    settle();

    for (int p = 0; p < 7; p++) begin
      set_idling(p < 2 ? 0 : (p < 4 ? 1 : 2));
      case (p)
        0: apply_settings(16'd2, 16'd50, 16'd10, 4'h8);
        1: apply_settings(16'd0, 16'd0, 16'd0, 4'hF);
        2: apply_settings(16'd1, 16'd3, 16'd2, 4'($urandom_range(15)));
        3: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0);
        4: apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 4'hF);
        5: apply_settings(16'd0, 16'd1, 16'hFFFF, 4'h0);
        default: apply_settings(16'($urandom_range(4)), 16'($urandom_range(6)),
                                16'($urandom_range(4)), 4'($urandom_range(15)));
      endcase
      run_random(120);
      settle();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("key_debounce_autorepeat_tb OK");
    end else begin
      $display("key_debounce_autorepeat_tb NOT OK");
    end
    $finish;
  end

endmodule
